// ----- design/osvf_pkg.sv -----
package osvf_pkg;

  // Sizes
  localparam int CHANNELS_DEF = 3;
  localparam int REG_CH       = 3;

  // Coefficient constants (Q0.24 and Q0.30)
  localparam logic [23:0] K_Q24       = 24'd8714969;
  localparam logic [29:0] INV6_Q30    = 30'd178956971;
  localparam logic [29:0] INV120_Q30  = 30'd8947849;
  localparam logic [29:0] INV5040_Q30 = 30'd213044;

  localparam logic [15:0] MIN_CUTOFF_RST = 16'd27;

  // Mode codes
  localparam logic [2:0] MODE_BYPASS = 3'd0;
  localparam logic [2:0] MODE_LOW    = 3'd1;
  localparam logic [2:0] MODE_HIGH   = 3'd2;
  localparam logic [2:0] MODE_BAND   = 3'd3;
  localparam logic [2:0] MODE_NOTCH  = 3'd4;

  // Register indexes
  localparam logic [2:0] REG_MODE0   = 3'd0;
  localparam logic [2:0] REG_MODE1   = 3'd1;
  localparam logic [2:0] REG_MODE2   = 3'd2;
  localparam logic [2:0] REG_RES0    = 3'd3;
  localparam logic [2:0] REG_RES1    = 3'd4;
  localparam logic [2:0] REG_RES2    = 3'd5;
  localparam logic [2:0] REG_MINCUT  = 3'd6;

  // Averaged filter outputs of one lane
  typedef struct packed {
    logic signed [31:0] lp;
    logic signed [31:0] hp;
    logic signed [31:0] bp;
  } lane_res_t;

  function automatic logic signed [31:0] sat32(input logic signed [34:0] v);
    logic signed [31:0] r;
    if (v > 35'sd2147483647) r = 32'sh7FFFFFFF;
    else if (v < -35'sd2147483648) r = 32'sh80000000;
    else r = v[31:0];
    return r;
  endfunction

  function automatic logic signed [23:0] sat24(input logic signed [32:0] v);
    logic signed [23:0] r;
    if (v > 33'sd8388607) r = 24'sh7FFFFF;
    else if (v < -33'sd8388608) r = 24'sh800000;
    else r = v[23:0];
    return r;
  endfunction

endpackage

// ----- design/oversampled_state_variable_filter_top.sv -----
// Channel | Direction | Handshake             | Payload
// cfg     | in        | cfg_we_i              | cfg_idx_i, cfg_data_i
// in      | in        | in_valid_i/in_ready_o | channel, left/right sample, cutoff
// out     | out       | out_valid_o/out_ready_i | left/right filtered
//
// A taken word passes through 9 coefficient steps (one shared 30x30 multiplier),
// 9 phases in each side's lane (one multiplier, three phases per iteration) and
// 9 digits in the radix-16 divide-by-three averagers, then is merged, saturated
// and moved to the output register. Bypass words go straight to the output
// register. Reset clears filter state and registers at once.
// The output register holds a word while out_ready_i is low;
// a new word is taken once the previous one has moved to the output register.
module oversampled_state_variable_filter_top #(
  parameter int CHANNELS = osvf_pkg::CHANNELS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [2:0]         cfg_idx_i,
  input  logic [15:0]        cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [1:0]         channel_i,
  input  logic signed [23:0] left_sample_i,
  input  logic signed [23:0] right_sample_i,
  input  logic [15:0]        cutoff_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [23:0] left_filtered_o,
  output logic signed [23:0] right_filtered_o
);
  import osvf_pkg::*;

  localparam int IDXW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  typedef enum logic [1:0] {S_IDLE, S_COEF, S_FILT, S_DONE} state_e;

  state_e             state_q;
  logic [2:0]         mode_q [REG_CH];
  logic [15:0]        res_q  [REG_CH];
  logic [15:0]        mincut_q;
  logic [2:0]         imode_q;
  logic [IDXW-1:0]    ch_q;
  logic [16:0]        damp_q;
  logic signed [23:0] xl_q, xr_q, yl_q, yr_q;
  logic               out_valid_q;
  logic signed [23:0] out_l_q, out_r_q;

  logic        accept, active, coef_done, lane_done, lane_done_r;
  logic [2:0]  cur_mode;
  logic [15:0] cur_res, cut_c;
  logic [16:0] coef;
  lane_res_t   res_l, res_r;

  // Register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < REG_CH; i++) begin
        mode_q[i] <= MODE_BYPASS;
        res_q[i]  <= '0;
      end
      mincut_q <= MIN_CUTOFF_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_MODE0:  mode_q[0] <= cfg_data_i[2:0];
        REG_MODE1:  mode_q[1] <= cfg_data_i[2:0];
        REG_MODE2:  mode_q[2] <= cfg_data_i[2:0];
        REG_RES0:   res_q[0]  <= cfg_data_i;
        REG_RES1:   res_q[1]  <= cfg_data_i;
        REG_RES2:   res_q[2]  <= cfg_data_i;
        REG_MINCUT: mincut_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Word decode
  assign accept   = in_valid_i && in_ready_o;
  assign cur_mode = (channel_i < 2'd3) ? mode_q[channel_i] : MODE_BYPASS;
  assign cur_res  = (channel_i < 2'd3) ? res_q[channel_i] : 16'd0;
  assign active   = (32'(channel_i) < CHANNELS) && (channel_i < 2'd3) &&
                    (cur_mode >= MODE_LOW) && (cur_mode <= MODE_NOTCH);
  assign cut_c    = (cutoff_i < mincut_q) ? mincut_q : cutoff_i;

  osvf_coef u_coef (
    .clk_i, .rst_ni,
    .start_i (accept && active),
    .cut_i   (cut_c),
    .done_o  (coef_done),
    .coef_o  (coef)
  );

  osvf_lane #(.CHANNELS(CHANNELS), .IDXW(IDXW)) u_lane_l (
    .clk_i, .rst_ni, .start_i(coef_done), .ch_i(ch_q), .x_i(xl_q),
    .coef_i(coef), .damp_i(damp_q), .done_o(lane_done), .res_o(res_l)
  );

  osvf_lane #(.CHANNELS(CHANNELS), .IDXW(IDXW)) u_lane_r (
    .clk_i, .rst_ni, .start_i(coef_done), .ch_i(ch_q), .x_i(xr_q),
    .coef_i(coef), .damp_i(damp_q), .done_o(lane_done_r), .res_o(res_r)
  );

  // Merge: pick the mode's output and saturate
  function automatic logic signed [23:0] merge(input logic [2:0] md, input lane_res_t r);
    logic signed [32:0] v;
    case (md)
      MODE_LOW:  v = 33'(r.lp);
      MODE_HIGH: v = 33'(r.hp);
      MODE_BAND: v = 33'(r.bp);
      default:   v = 33'(r.lp) + 33'(r.hp);
    endcase
    return sat24(v);
  endfunction

  assign in_ready_o = (state_q == S_IDLE);

  // Control and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      out_l_q     <= '0;
      out_r_q     <= '0;
    end else begin
      case (state_q)
        S_IDLE: if (accept) state_q <= active ? S_COEF : S_DONE;
        S_COEF: if (coef_done) state_q <= S_FILT;
        S_FILT: if (lane_done && lane_done_r) state_q <= S_DONE;
        S_DONE: begin
          if (!out_valid_q || out_ready_i) begin
            out_l_q <= yl_q;
            out_r_q <= yr_q;
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
      if (state_q == S_DONE && (!out_valid_q || out_ready_i)) out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      imode_q <= cur_mode;
      ch_q    <= IDXW'(channel_i);
      damp_q  <= 17'h10000 - 17'(cur_res);
      xl_q    <= left_sample_i;
      xr_q    <= right_sample_i;
      yl_q    <= left_sample_i;
      yr_q    <= right_sample_i;
    end else if (state_q == S_FILT && lane_done && lane_done_r) begin
      yl_q <= merge(imode_q, res_l);
      yr_q <= merge(imode_q, res_r);
    end
  end

  assign out_valid_o      = out_valid_q;
  assign left_filtered_o  = out_l_q;
  assign right_filtered_o = out_r_q;

endmodule

// ----- design/osvf_coef.sv -----
module osvf_coef (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [15:0] cut_i,
  output logic        done_o,
  output logic [16:0] coef_o
);
  import osvf_pkg::*;

  logic        busy_q;
  logic [3:0]  step_q;
  logic        done_q;
  logic [15:0] cut_q;
  logic [29:0] fx_q, fx2_q, fx3_q, fx5_q, fx7_q, t3_q, t5_q, t7_q;
  logic [16:0] coef_q;
  logic [29:0] op_a, op_b;
  logic [59:0] prod;
  logic [29:0] rnd0, rnd;
  logic [30:0] sum;
  logic [30:0] sum_r;

  // Operand select for the shared multiplier
  always_comb begin
    case (step_q)
      4'd0: begin op_a = {14'd0, cut_q}; op_b = {6'd0, K_Q24}; end
      4'd1: begin op_a = fx_q;  op_b = fx_q;        end
      4'd2: begin op_a = fx2_q; op_b = fx_q;        end
      4'd3: begin op_a = fx3_q; op_b = fx2_q;       end
      4'd4: begin op_a = fx3_q; op_b = INV6_Q30;    end
      4'd5: begin op_a = fx5_q; op_b = fx2_q;       end
      4'd6: begin op_a = fx5_q; op_b = INV120_Q30;  end
      4'd7: begin op_a = fx7_q; op_b = INV5040_Q30; end
      default: begin op_a = '0; op_b = '0; end
    endcase
  end

  assign prod  = op_a * op_b;
  assign rnd0  = 30'((prod + 60'd512) >> 10);
  assign rnd   = 30'((prod + 60'd536870912) >> 30);
  assign sum   = {1'b0, fx_q} - {1'b0, t3_q} + {1'b0, t5_q} - {1'b0, t7_q};
  assign sum_r = sum + 31'd4096;

  // Step sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      step_q <= '0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        step_q <= '0;
      end else if (busy_q) begin
        if (step_q == 4'd8) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
        step_q <= step_q + 4'd1;
      end
    end
  end

  // Product registers
  always_ff @(posedge clk_i) begin
    if (start_i) cut_q <= cut_i;
    if (busy_q) begin
      case (step_q)
        4'd0: fx_q  <= rnd0;
        4'd1: fx2_q <= rnd;
        4'd2: fx3_q <= rnd;
        4'd3: fx5_q <= rnd;
        4'd4: t3_q  <= rnd;
        4'd5: fx7_q <= rnd;
        4'd6: t5_q  <= rnd;
        4'd7: t7_q  <= rnd;
        4'd8: coef_q <= sum_r[29:13];
        default: ;
      endcase
    end
  end

  assign done_o = done_q;
  assign coef_o = coef_q;

endmodule

// ----- design/osvf_div3.sv -----
module osvf_div3 (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [33:0] u_i,
  output logic        done_o,
  output logic [32:0] q_o
);

  logic        busy_q, done_q;
  logic [3:0]  cnt_q;
  logic [35:0] num_q, quo_q;
  logic [1:0]  rem_q;
  logic [5:0]  v;
  logic [10:0] vm;
  logic [3:0]  qd;
  logic [5:0]  rem_n;

  // One radix-16 digit per cycle; v < 48 so v*43>>7 equals v/3
  assign v     = {rem_q, num_q[35:32]};
  assign vm    = 11'(v) * 11'd43;
  assign qd    = vm[10:7];
  assign rem_n = v - 6'(qd) * 6'd3;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 4'd1;
        if (cnt_q == 4'd8) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      num_q <= {2'b00, u_i};
      rem_q <= '0;
    end else if (busy_q) begin
      num_q <= {num_q[31:0], 4'd0};
      quo_q <= {quo_q[31:0], qd};
      rem_q <= rem_n[1:0];
    end
  end

  assign done_o = done_q;
  assign q_o    = quo_q[32:0];

endmodule

// ----- design/osvf_lane.sv -----
module osvf_lane #(
  parameter int CHANNELS = osvf_pkg::CHANNELS_DEF,
  parameter int IDXW     = (CHANNELS > 1) ? $clog2(CHANNELS) : 1
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,
  input  logic [IDXW-1:0]          ch_i,
  input  logic signed [23:0]       x_i,
  input  logic [16:0]              coef_i,
  input  logic [16:0]              damp_i,
  output logic                     done_o,
  output osvf_pkg::lane_res_t      res_o
);
  import osvf_pkg::*;

  logic signed [31:0] lp_st_q [CHANNELS];
  logic signed [31:0] bp_st_q [CHANNELS];

  logic               busy_q, div_start_q;
  logic [1:0]         phase_q, iter_q;
  logic [IDXW-1:0]    ch_q;
  logic signed [23:0] x_q;
  logic [16:0]        coef_q, damp_q;
  logic signed [31:0] lp_q, hp_q, bp_q;
  logic signed [33:0] slp_q, shp_q, sbp_q;

  logic [16:0]        mul_a;
  logic signed [31:0] mul_b;
  logic signed [49:0] prod, prod_r;
  logic signed [33:0] m;
  logic signed [31:0] lp_n, hp_n, bp_n;
  logic               last;

  // Shared multiplier: f*bp, damp*bp, f*hp in the three phases
  assign mul_a  = (phase_q == 2'd1) ? damp_q : coef_q;
  assign mul_b  = (phase_q == 2'd2) ? hp_q : bp_q;
  assign prod   = $signed({1'b0, mul_a}) * mul_b;
  assign prod_r = prod + 50'sd32768;
  assign m      = prod_r[49:16];

  assign lp_n = sat32(35'(lp_q) + 35'(m));
  assign hp_n = sat32(35'(x_q) - 35'(lp_q) - 35'(m));
  assign bp_n = sat32(35'(bp_q) + 35'(m));
  assign last = busy_q && (phase_q == 2'd2) && (iter_q == 2'd2);

  // Iteration control and state store
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      div_start_q <= 1'b0;
      phase_q     <= '0;
      iter_q      <= '0;
      for (int i = 0; i < CHANNELS; i++) begin
        lp_st_q[i] <= '0;
        bp_st_q[i] <= '0;
      end
    end else begin
      div_start_q <= last;
      if (start_i) begin
        busy_q  <= 1'b1;
        phase_q <= '0;
        iter_q  <= '0;
      end else if (busy_q) begin
        if (phase_q == 2'd2) begin
          phase_q <= '0;
          iter_q  <= iter_q + 2'd1;
        end else begin
          phase_q <= phase_q + 2'd1;
        end
        if (last) begin
          busy_q       <= 1'b0;
          lp_st_q[ch_q] <= lp_q;
          bp_st_q[ch_q] <= bp_n;
        end
      end
    end
  end

  // Working registers and running sums
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      ch_q   <= ch_i;
      x_q    <= x_i;
      coef_q <= coef_i;
      damp_q <= damp_i;
      lp_q   <= lp_st_q[ch_i];
      bp_q   <= bp_st_q[ch_i];
      slp_q  <= '0;
      shp_q  <= '0;
      sbp_q  <= '0;
    end else if (busy_q) begin
      case (phase_q)
        2'd0: begin lp_q <= lp_n; slp_q <= slp_q + 34'(lp_n); end
        2'd1: begin hp_q <= hp_n; shp_q <= shp_q + 34'(hp_n); end
        default: begin bp_q <= bp_n; sbp_q <= sbp_q + 34'(bp_n); end
      endcase
    end
  end

  // Averages: floor((s+1)/3), biased to stay non-negative
  logic signed [35:0] ul, uh, ub;
  logic [32:0]        ql, qh, qb;
  logic               dl, dh, db;
  logic [32:0]        al, ah, ab;

  assign ul = 36'(slp_q) + 36'sd6442450945;
  assign uh = 36'(shp_q) + 36'sd6442450945;
  assign ub = 36'(sbp_q) + 36'sd6442450945;

  osvf_div3 u_div_lp (.clk_i, .rst_ni, .start_i(div_start_q), .u_i(ul[33:0]),
                      .done_o(dl), .q_o(ql));
  osvf_div3 u_div_hp (.clk_i, .rst_ni, .start_i(div_start_q), .u_i(uh[33:0]),
                      .done_o(dh), .q_o(qh));
  osvf_div3 u_div_bp (.clk_i, .rst_ni, .start_i(div_start_q), .u_i(ub[33:0]),
                      .done_o(db), .q_o(qb));

  assign al = ql - 33'd2147483648;
  assign ah = qh - 33'd2147483648;
  assign ab = qb - 33'd2147483648;

  assign done_o   = dl & dh & db;
  assign res_o.lp = al[31:0];
  assign res_o.hp = ah[31:0];
  assign res_o.bp = ab[31:0];

endmodule

// ----- design/osvf_checker.sv -----
module osvf_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_ready_o,
  input logic               out_valid_o,
  input logic               out_ready_i,
  input logic signed [23:0] left_filtered_o,
  input logic signed [23:0] right_filtered_o
);

  // A taken word keeps the block busy for at least the next cycle
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input taken again right after accept");

  // A new result only appears when the block was busy in the cycle before
  a_result_after_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(!in_ready_o))
    else $error("result without preceding work");

  // Stalled result stays
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result dropped under stall");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(left_filtered_o) && $stable(right_filtered_o))
    else $error("result changed under stall");

endmodule

bind oversampled_state_variable_filter_top osvf_checker u_osvf_checker (.*);
